@@ hdl/tslc_pkg.sv @@
// ---------------------------------------------------------------------------
// tslc_pkg
// Types and codes shared by the timed lookup cache.
// ---------------------------------------------------------------------------
`default_nettype none
package tslc_pkg;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } tslc_op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } tslc_status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_READ,
    S_EXEC
  } tslc_state_t;

  typedef struct packed {
    logic [31:0] etime;
    logic [30:0] ehash;
    logic [63:0] ekey;
    logic [63:0] epayload;
    logic [7:0]  eerror;
  } tslc_entry_t;

  localparam int unsigned ENTRY_W   = $bits(tslc_entry_t);
  localparam logic [15:0] MAX_AGE_RST = 16'd5;

endpackage
`default_nettype wire

@@ hdl/timed_set_associative_lookup_cache_unit.sv @@
// ---------------------------------------------------------------------------
// timed_set_associative_lookup_cache_unit
// Set-associative get/add/remove cache with time-based replacement.
// ---------------------------------------------------------------------------
// After reset the unit holds busy while it zeroes the row store, one bucket
// row per cycle. A transaction then runs from start to the done strobe through
// the bucket index (the idx register of the modulo unit when BUCKETS is a power
// of two, else its stage1, stage2 and done registers), one row read and one
// compare-and-write-back step; the next start is accepted from the cycle in
// which done is high. Done is high for a single cycle; the result outputs hold
// until the next transaction ends, and they cannot be held off.
`default_nettype none
module timed_set_associative_lookup_cache_unit #(
  parameter int unsigned BUCKETS = 1024,
  parameter int unsigned WAYS    = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  operation,
  input  wire logic [30:0] key_hash,
  input  wire logic [63:0] key_id,
  input  wire logic [31:0] current_time,
  input  wire logic [7:0]  error_code,
  input  wire logic        payload_present,
  input  wire logic [63:0] payload_in,
  input  wire logic        max_age_we,
  input  wire logic [15:0] max_age,
  output logic             done,
  output logic [1:0]       status,
  output logic [7:0]       cached_error,
  output logic [63:0]      payload_out,
  output logic             payload_valid,
  output logic [2:0]       way_used
);

  import tslc_pkg::*;

  localparam int unsigned AW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned ROW_W = WAYS * ENTRY_W;

  tslc_state_t state, state_next;

  logic [15:0]   max_age_q;
  logic [AW-1:0] clr_addr;
  logic [1:0]    r_op;
  logic [30:0]   r_hash;
  logic [63:0]   r_key;
  logic [31:0]   r_now;
  logic [7:0]    r_err;
  logic          r_pp;
  logic [63:0]   r_payload;

  logic          mod_done;
  logic [AW-1:0] bucket;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] ram_rdata;

  tslc_entry_t [WAYS-1:0] row;
  tslc_entry_t [WAYS-1:0] row_new;
  logic          hit, free_found;
  logic [WW-1:0] hit_way, free_way;

  logic             accept;
  logic [1:0]       status_next;
  logic [7:0]       cerr_next;
  logic [63:0]      pout_next;
  logic             pvalid_next;
  logic [2:0]       way_next;

  assign accept = start && (state == S_IDLE);

  tslc_bucket_mod #(.BUCKETS(BUCKETS), .AW(AW)) u_mod (
    .clk(clk), .rst(rst), .start(accept), .value(key_hash),
    .done(mod_done), .bucket(bucket)
  );

  tslc_row_ram #(.DEPTH(BUCKETS), .AW(AW), .DW(ROW_W)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(mod_done), .raddr(bucket), .rdata(ram_rdata)
  );

  assign row = ram_rdata;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_addr == AW'(BUCKETS - 1)) state_next = S_IDLE;
      S_IDLE:  if (start) state_next = S_MOD;
      S_MOD:   if (mod_done) state_next = S_READ;
      S_READ:  state_next = S_EXEC;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != S_IDLE);
  end

  // way search
  always_comb begin
    logic [32:0] t, lim_err, lim_age, now_w;
    hit        = 1'b0;
    free_found = 1'b0;
    hit_way    = '0;
    free_way   = '0;
    now_w      = {1'b0, r_now};
    for (int w = WAYS - 1; w >= 0; w--) begin
      t       = {1'b0, row[w].etime};
      lim_err = t + 33'd1;
      lim_age = t + {17'd0, max_age_q};
      if (row[w].etime != 32'd0 && row[w].ehash == r_hash && row[w].ekey == r_key) begin
        hit     = 1'b1;
        hit_way = WW'(w);
      end
      if (row[w].etime == 32'd0 || (row[w].eerror != 8'd0 && now_w > lim_err)
          || now_w > lim_age) begin
        free_found = 1'b1;
        free_way   = WW'(w);
      end
    end
  end

  always_comb begin
    row_new     = row;
    ram_we      = 1'b0;
    ram_waddr   = bucket;
    status_next = ST_MISS;
    cerr_next   = '0;
    pout_next   = '0;
    pvalid_next = 1'b0;
    way_next    = '0;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      row_new   = '0;
    end else if (state == S_EXEC) begin
      case (r_op)
        OP_GET: begin
          if (hit) begin
            status_next = ST_OK;
            way_next    = 3'(hit_way);
            cerr_next   = row[hit_way].eerror;
            if (row[hit_way].eerror == 8'd0) begin
              pout_next   = row[hit_way].epayload;
              pvalid_next = 1'b1;
            end
          end
        end
        OP_ADD: begin
          status_next = ST_FULL;
          if (free_found) begin
            status_next = ST_OK;
            way_next    = 3'(free_way);
            ram_we      = 1'b1;
            row_new[free_way].ehash  = r_hash;
            row_new[free_way].ekey   = r_key;
            row_new[free_way].eerror = r_err;
            row_new[free_way].etime  = r_now;
            if (r_pp) begin
              row_new[free_way].epayload = r_payload;
            end
          end
        end
        OP_REMOVE: begin
          if (hit) begin
            status_next = ST_OK;
            way_next    = 3'(hit_way);
            ram_we      = 1'b1;
            row_new[hit_way].etime = '0;
          end
        end
        default: ;
      endcase
    end
    ram_wdata = row_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      max_age_q <= MAX_AGE_RST;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_EXEC);
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (max_age_we) begin
        max_age_q <= max_age;
      end
    end
    if (accept) begin
      r_op      <= operation;
      r_hash    <= key_hash;
      r_key     <= key_id;
      r_now     <= current_time;
      r_err     <= error_code;
      r_pp      <= payload_present;
      r_payload <= payload_in;
    end
    if (state == S_EXEC) begin
      status        <= status_next;
      cached_error  <= cerr_next;
      payload_out   <= pout_next;
      payload_valid <= pvalid_next;
      way_used      <= way_next;
    end
  end

endmodule
`default_nettype wire

@@ hdl/tslc_bucket_mod.sv @@
// ---------------------------------------------------------------------------
// tslc_bucket_mod
// Bucket index: key hash modulo BUCKETS, by its low bits for a power-of-two BUCKETS, else by reciprocal multiplication.
// ---------------------------------------------------------------------------
`default_nettype none
module tslc_bucket_mod #(
  parameter int unsigned BUCKETS = 1024,
  parameter int unsigned AW      = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [30:0]   value,
  output logic               done,
  output logic [AW-1:0]      bucket
);

  generate
    if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_pow2
      logic [AW-1:0] idx;
      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
        if (start) begin
          idx <= (BUCKETS > 1) ? value[AW-1:0] : '0;
        end
      end
      assign bucket = idx;
    end else begin : g_div
      // quotient = (value * ceil(2^SH / BUCKETS)) >> SH, exact for 31-bit values
      localparam int unsigned     SH    = 31 + $clog2(BUCKETS);
      localparam longint unsigned NUM   = 64'd1 << SH;
      localparam longint unsigned RECIP = (NUM + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
      localparam logic [31:0]     MREC  = 32'(RECIP);
      localparam logic [30:0]     BMUL  = 31'(BUCKETS);
      logic          stage1;
      logic          stage2;
      logic [30:0]   val_q;
      logic [62:0]   prod;
      logic [30:0]   quot;
      logic [30:0]   qmul;
      logic [30:0]   rem;

      assign quot = 31'(prod >> SH);
      assign qmul = quot * BMUL;

      always_ff @(posedge clk) begin
        if (rst) begin
          stage1 <= 1'b0;
          stage2 <= 1'b0;
          done   <= 1'b0;
        end else begin
          stage1 <= start;
          stage2 <= stage1;
          done   <= stage2;
        end
        if (start) begin
          val_q <= value;
        end
        if (stage1) begin
          prod <= 63'(val_q) * 63'(MREC);
        end
        if (stage2) begin
          rem <= val_q - qmul;
        end
      end
      assign bucket = rem[AW-1:0];
    end
  endgenerate

endmodule
`default_nettype wire

@@ hdl/tslc_row_ram.sv @@
// ---------------------------------------------------------------------------
// tslc_row_ram
// Bucket row store, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none
module tslc_row_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
